FILE: src/sust_pkg.sv
// sust_pkg: shared types, constants and a helper function for the sorted unique set table
// used by sust_ctrl, sust_dpath and sorted_unique_set_table; no dependencies
package sust_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int ACT_W    = 2;
  localparam int STS_W    = 3;
  localparam int POS_W    = 5;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_DELETE = 2'd2
  } action_t;

  typedef enum logic [STS_W-1:0] {
    STS_INSERTED = 3'd0,
    STS_PRESENT  = 3'd1,
    STS_FOUND    = 3'd2,
    STS_MISSING  = 3'd3,
    STS_REMOVED  = 3'd4,
    STS_EMPTY    = 3'd5,
    STS_FULL     = 3'd6
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_UPDATE
  } state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  // index of the set bit in a one-hot row
  function automatic logic [IDX_W-1:0] onehot_index(input logic [CAPACITY-1:0] row);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (row[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

FILE: src/sust_ctrl.sv
// sust_ctrl: two-state controller that sequences capture and commit of one request
// depends on sust_pkg
module sust_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sust_pkg::stat_t stat,
  output sust_pkg::cmd_t  cmd
);
  import sust_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_UPDATE: begin
        cmd.commit = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

FILE: src/sust_dpath.sv
// sust_dpath: row of compare cells holding the sorted values, count and result register
// depends on sust_pkg; driven by sust_ctrl commands
module sust_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [sust_pkg::ACT_W-1:0]          action,
  input  logic signed [sust_pkg::KEY_W-1:0]   key_value,
  input  sust_pkg::cmd_t                      cmd,
  output sust_pkg::stat_t                     stat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sust_pkg::STS_W-1:0]          status,
  output logic [sust_pkg::POS_W-1:0]          position,
  output logic [sust_pkg::POS_W-1:0]          entry_count
);
  import sust_pkg::*;

  logic signed [KEY_W-1:0] entries [CAPACITY];
  logic signed [KEY_W-1:0] ins_row [CAPACITY];
  logic signed [KEY_W-1:0] del_row [CAPACITY];
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic [ACT_W-1:0]        act_q;
  logic signed [KEY_W-1:0] key_q;
  logic [CAPACITY-1:0]     lt_q;
  logic [CAPACITY-1:0]     eq_q;
  logic [CAPACITY-1:0]     lt_next;
  logic [CAPACITY-1:0]     eq_next;
  logic                    hit;
  logic                    empty;
  logic                    full;
  logic                    do_insert;
  logic                    do_delete;
  status_t                 res_status;
  logic [POS_W-1:0]        res_pos;

  // compare cells against the incoming word
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt_next[i] = (CNT_W'(i) < count) && (entries[i] < key_value);
      eq_next[i] = (CNT_W'(i) < count) && (entries[i] == key_value);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q <= action;
      key_q <= key_value;
      lt_q  <= lt_next;
      eq_q  <= eq_next;
    end
  end

  // shifted rows for insert and delete
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ins_row[i] = entries[i];
      del_row[i] = entries[i];
    end
    if (!lt_q[0]) begin
      ins_row[0] = key_q;
    end
    for (int i = 1; i < CAPACITY; i++) begin
      if (!lt_q[i]) begin
        ins_row[i] = lt_q[i-1] ? key_q : entries[i-1];
      end
    end
    for (int i = 0; i < CAPACITY - 1; i++) begin
      if (!lt_q[i]) begin
        del_row[i] = entries[i+1];
      end
    end
  end

  assign hit   = |eq_q;
  assign empty = (count == '0);
  assign full  = (count == CNT_W'(CAPACITY));

  always_comb begin
    do_insert  = 1'b0;
    do_delete  = 1'b0;
    res_pos    = '0;
    count_next = count;
    case (act_q)
      ACT_INSERT: begin
        if (hit) begin
          res_status = STS_PRESENT;
        end else if (full) begin
          res_status = STS_FULL;
        end else begin
          res_status = STS_INSERTED;
          do_insert  = 1'b1;
          count_next = count + 1'b1;
        end
      end
      ACT_DELETE: begin
        if (empty) begin
          res_status = STS_EMPTY;
        end else if (!hit) begin
          res_status = STS_MISSING;
        end else begin
          res_status = STS_REMOVED;
          do_delete  = 1'b1;
          count_next = count - 1'b1;
        end
      end
      default: begin
        if (empty) begin
          res_status = STS_EMPTY;
        end else if (hit) begin
          res_status = STS_FOUND;
          res_pos    = POS_W'({1'b0, onehot_index(eq_q)}) + 1'b1;
        end else begin
          res_status = STS_MISSING;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && do_insert) begin
      entries <= ins_row;
    end else if (cmd.commit && do_delete) begin
      entries <= del_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status      <= res_status;
      position    <= res_pos;
      entry_count <= POS_W'(count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.out_free = !out_valid || out_ready;

endmodule

FILE: src/sorted_unique_set_table.sv
// sorted_unique_set_table: sorted set of signed words with insert, search and delete
// the result register loads in S_UPDATE after a word is accepted, later while the last result waits
// a new word is taken only in S_IDLE, after the compare and shift/commit steps of the last word
// the result register lets the next word in while a result waits to be taken
// reset: set emptied, no result pending; stored values undefined until written
// depends on sust_pkg, sust_ctrl, sust_dpath
module sorted_unique_set_table (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [sust_pkg::ACT_W-1:0]         action,
  input  logic signed [sust_pkg::KEY_W-1:0]  key_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [sust_pkg::STS_W-1:0]         status,
  output logic [sust_pkg::POS_W-1:0]         position,
  output logic [sust_pkg::POS_W-1:0]         entry_count
);
  import sust_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sust_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sust_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .action      (action),
    .key_value   (key_value),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .position    (position),
    .entry_count (entry_count)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("word accepted while previous request still in flight");

  a_commit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> stat.out_free)
    else $error("commit while result register still holds an untaken word");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count <= POS_W'(CAPACITY))
    else $error("entry count above capacity");

  a_position_found: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((status == STS_FOUND) == (position != '0)))
    else $error("position disagrees with status");

  a_insert_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STS_INSERTED || status == STS_REMOVED ||
                  status == STS_FOUND) |-> (status != STS_INSERTED) || (entry_count != '0))
    else $error("insert reported with empty set");

endmodule
